FILE: rtl/core/ndd_pkg.sv
// Shared types and constants for the Newton divided-difference interpolator.
`timescale 1ns / 1ps
package ndd_pkg;

	// Commands carried by an input transfer
	localparam logic [1:0] CMD_SET    = 2'd0;
	localparam logic [1:0] CMD_MOVE   = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	// Register map
	localparam int         PAW              = 3;
	localparam logic [2:0] ADDR_POINT_COUNT = 3'd0;

	// Fixed point
	localparam logic signed [63:0] Q_SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [16:0]        T_ONE     = 17'd65536;
	localparam logic signed [63:0] PROD_ONE  = 64'sd65536;

	// Divider retires this many quotient bits per cycle
	localparam int DIV_BITS  = 8;
	localparam int DIV_STEPS = 64 / DIV_BITS;

	typedef logic [3:0][31:0] pv_row_t;
	typedef logic [3:0][63:0] tab_row_t;

endpackage

FILE: rtl/core/ndd_div.sv
// Multi-cycle signed divider: 64-bit dividend by a narrow divisor, truncating.
`timescale 1ns / 1ps
module ndd_div import ndd_pkg::*; #(
	parameter int DW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   num,
	input  logic signed [DW:0]   den,
	output logic                 done,
	output logic signed [63:0]   quot
);

	logic [63:0]   mag_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dmag_q;
	logic          neg_q;
	logic          zero_q;
	logic          run_q;
	logic          done_q;
	logic [$clog2(DIV_STEPS)-1:0] cnt_q;
	logic [63:0]   mag_d;
	logic [DW-1:0] rem_d;
	logic [DW:0]   den_abs;

	assign den_abs = den[DW] ? (-den) : den;

	// Restoring division, DIV_BITS quotient bits per cycle
	always_comb begin
		logic [DW:0]  r;
		logic [63:0]  m;
		m = mag_q;
		r = {1'b0, rem_q};
		for (int k = 0; k < DIV_BITS; k++) begin
			r = {r[DW-1:0], m[63]};
			m = {m[62:0], 1'b0};
			if (r >= {1'b0, dmag_q}) begin
				r    = r - {1'b0, dmag_q};
				m[0] = 1'b1;
			end
		end
		mag_d = m;
		rem_d = r[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mag_q  <= '0;
			rem_q  <= '0;
			dmag_q <= '0;
			neg_q  <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mag_q  <= num[63] ? (64'd0 - 64'(unsigned'(num))) : 64'(unsigned'(num));
				rem_q  <= '0;
				dmag_q <= den_abs[DW-1:0];
				neg_q  <= num[63] ^ den[DW];
				zero_q <= (den == '0);
				cnt_q  <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				mag_q <= mag_d;
				rem_q <= rem_d;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(DIV_STEPS))'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = zero_q ? 64'sd0 : (neg_q ? -$signed(mag_q) : $signed(mag_q));

endmodule

FILE: rtl/core/ndd_mul.sv
// Multi-cycle Q.16 multiplier: exact 64x64 product from 32x32 partials, >>16, saturated.
`timescale 1ns / 1ps
module ndd_mul import ndd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic signed [63:0] prod
);

	logic [63:0]        ma_q;
	logic [63:0]        mb_q;
	logic               neg_q;
	logic [127:0]       acc_q;
	logic [63:0]        pp_s1;
	logic [1:0]         sel_s1;
	logic               pp_vld_s1;
	logic               run_q;
	logic [2:0]         cnt_q;
	logic               done_q;
	logic signed [63:0] res_q;
	logic [31:0]        opa;
	logic [31:0]        opb;
	logic [63:0]        pp;
	logic [127:0]       addend;
	logic [63:0]        rlo;
	logic [47:0]        rhi;
	logic [63:0]        rmag;

	// Partial product select: bit 1 picks the high half of a, bit 0 of b
	assign opa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign opb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp  = opa * opb;

	always_comb begin
		case (sel_s1)
			2'd0:    addend = {64'd0, pp_s1};
			2'd3:    addend = {pp_s1, 64'd0};
			default: addend = {32'd0, pp_s1, 32'd0};
		endcase
	end

	// Drop 16 fraction bits and saturate the magnitude
	assign rlo  = acc_q[79:16];
	assign rhi  = acc_q[127:80];
	assign rmag = ((rhi != '0) || rlo[63]) ? 64'(unsigned'(Q_SAT_MAX)) : rlo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			pp_vld_s1 <= 1'b0;
			ma_q      <= '0;
			mb_q      <= '0;
			neg_q     <= 1'b0;
			acc_q     <= '0;
			pp_s1     <= '0;
			sel_s1    <= '0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ma_q      <= a[63] ? (64'd0 - 64'(unsigned'(a))) : 64'(unsigned'(a));
				mb_q      <= b[63] ? (64'd0 - 64'(unsigned'(b))) : 64'(unsigned'(b));
				neg_q     <= a[63] ^ b[63];
				acc_q     <= '0;
				cnt_q     <= '0;
				pp_vld_s1 <= 1'b0;
				run_q     <= 1'b1;
			end else if (run_q) begin
				cnt_q     <= cnt_q + 3'd1;
				pp_vld_s1 <= ~cnt_q[2];
				pp_s1     <= pp;
				sel_s1    <= cnt_q[1:0];
				if (pp_vld_s1) begin
					acc_q <= acc_q + addend;
				end
				if (cnt_q == 3'd5) begin
					res_q  <= neg_q ? -$signed(rmag) : $signed(rmag);
					done_q <= 1'b1;
					run_q  <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = res_q;

endmodule

FILE: rtl/core/newton_divided_difference_interp.sv
// Top level: point store, slot permutation, lazy divided-difference table and evaluator.
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  apb       in/out     psel/penable/pready    paddr, pwdata, prdata (point_count)
//  in        in         in_valid / in_stall    command, point_index, value_*, sample_position
//  out       out        out_valid / out_stall  result_x, result_y, result_z, result_w
//
//  Set stores a point and marks its slot stale; move swaps the point into the last slot. A
//  sample first rebuilds the stale part of the table (column 0 from the stored values, higher
//  entries by the 8-bit-per-cycle dividers), then sums its terms through the multipliers.
//  Reset clears the count, marks the table stale and restores identity slot order.
//  in_stall is high while a transfer is being worked; a finished sample waits in the
//  output register and only holds the sequencer if another result arrives first.
//
module newton_divided_difference_interp import ndd_pkg::*; #(
	parameter int MAX_POINTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PAW-1:0]      paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          command,
	input  logic [3:0]          point_index,
	input  logic signed [31:0]  value_x,
	input  logic signed [31:0]  value_y,
	input  logic signed [31:0]  value_z,
	input  logic signed [31:0]  value_w,
	input  logic [16:0]         sample_position,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  result_x,
	output logic signed [31:0]  result_y,
	output logic signed [31:0]  result_z,
	output logic signed [31:0]  result_w
);

	localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int TW  = 2 * IW;
	localparam int TSW = 17 + IW;
	localparam int FW  = TSW + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SET, ST_MV_SLOT, ST_MV_OTHER, ST_MV_SWAP,
		ST_RB0_POS, ST_RB0_VAL, ST_RB0_WR, ST_RB_RD, ST_RB_DIV, ST_RB_WR,
		ST_EV_RD, ST_EV_MUL, ST_EV_ACC, ST_OUT
	} state_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic signed [64:0] s;
		s = $signed({x[63], x}) + $signed({y[63], y});
		if (s > $signed({1'b0, Q_SAT_MAX})) return Q_SAT_MAX;
		if (s < -$signed({1'b0, Q_SAT_MAX})) return -Q_SAT_MAX;
		return s[63:0];
	endfunction

	function automatic logic [31:0] to_q16(input logic signed [63:0] v);
		logic [63:0] mag;
		logic [39:0] m;
		logic [39:0] nm;
		mag = v[63] ? (64'd0 - 64'(unsigned'(v))) : 64'(unsigned'(v));
		m   = mag[63:24];
		if (v[63]) begin
			if (m > 40'h80000000) m = 40'h80000000;
			nm = 40'd0 - m;
			return nm[31:0];
		end
		if (m > 40'h7FFFFFFF) m = 40'h7FFFFFFF;
		return m[31:0];
	endfunction

	// Control and working registers
	state_t                 state_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          stale_q;
	logic [CW-1:0]          d_q;
	logic [CW-1:0]          row_q;
	logic [CW-1:0]          col_q;
	logic [CW-1:0]          i_q;
	logic [IW-1:0]          idx_q;
	logic [IW-1:0]          s_q;
	logic [IW-1:0]          other_q;
	logic [TSW-1:0]         ts_q;
	logic signed [63:0]     acc_q [4];
	logic signed [63:0]     prod_q;
	logic                   out_valid_q;
	logic [3:0][31:0]       res_q;
	logic [MAX_POINTS-1:0]  pv_vld_q;
	logic [MAX_POINTS-1:0]  pos_vld_q;
	logic [MAX_POINTS-1:0]  slt_vld_q;

	// Memories and their registered read ports
	pv_row_t        pv_mem  [MAX_POINTS];
	logic [IW-1:0]  pos_mem [MAX_POINTS];
	logic [IW-1:0]  slt_mem [MAX_POINTS];
	tab_row_t       tab_mem [2**TW];

	pv_row_t        pv_rd_q;
	logic           pv_rvld_q;
	logic [IW-1:0]  pos_ra_q, pos_rb_q, pos_ra_addr_q, pos_rb_addr_q;
	logic           pos_ra_vld_q, pos_rb_vld_q;
	logic [IW-1:0]  slt_rd_q, slt_raddr_q;
	logic           slt_rvld_q;
	tab_row_t       tab_ra_q, tab_rb_q;

	// Memory port controls
	logic           pv_we;
	logic [IW-1:0]  pv_waddr, pv_raddr;
	pv_row_t        pv_wdata;
	logic           pos_we;
	logic [IW-1:0]  pos_waddr, pos_wdata, pos_ra_addr, pos_rb_addr;
	logic           slt_we;
	logic [IW-1:0]  slt_waddr, slt_wdata, slt_raddr;
	logic           tab_we;
	logic [TW-1:0]  tab_waddr, tab_ra_addr, tab_rb_addr;
	tab_row_t       tab_wdata;

	// Derived values
	logic               in_xfer;
	logic               idx_ok;
	logic [IW-1:0]      idx_in;
	logic [IW-1:0]      last;
	logic [16:0]        t_sat;
	pv_row_t            pv_eff;
	logic [IW-1:0]      pos_a, pos_b, slt_a;
	logic [CW-1:0]      col_m1, row_p1, row_pc;
	logic               cfg_wr;
	logic [CW-1:0]      cfg_n;
	logic               out_load;
	logic               div_start, mul_start;
	logic [3:0]         div_done, mul_done;
	logic               prod_done;
	logic signed [63:0] quot [4];
	logic signed [63:0] term [4];
	logic signed [63:0] prod_next;
	logic signed [IW:0] node_gap;
	logic signed [FW-1:0] fac;
	logic signed [63:0] fac_ext;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign idx_ok   = (32'(point_index) < 32'(cnt_q));
	assign idx_in   = IW'(point_index);
	assign last     = IW'(cnt_q - CW'(1));
	assign t_sat    = (sample_position > T_ONE) ? T_ONE : sample_position;
	assign pv_eff   = pv_rvld_q ? pv_rd_q : '0;
	assign pos_a    = pos_ra_vld_q ? pos_ra_q : pos_ra_addr_q;
	assign pos_b    = pos_rb_vld_q ? pos_rb_q : pos_rb_addr_q;
	assign slt_a    = slt_rvld_q ? slt_rd_q : slt_raddr_q;
	assign col_m1   = col_q - CW'(1);
	assign row_p1   = row_q + CW'(1);
	assign row_pc   = row_q + col_q;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_POINT_COUNT);
	assign cfg_n  = (32'(pwdata[4:0]) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(pwdata[4:0]);
	assign prdata = (paddr == ADDR_POINT_COUNT) ? 32'(cnt_q) : 32'd0;

	// Node distance and evaluation factor (ts - node)
	assign node_gap = $signed({1'b0, pos_a}) - $signed({1'b0, pos_b});
	assign fac      = $signed({1'b0, ts_q}) - $signed(FW'({pos_a, 16'd0}));
	assign fac_ext  = {{(64 - FW){fac[FW-1]}}, fac};

	// Arithmetic units: one divider and one term multiplier per component
	for (genvar c = 0; c < 4; c++) begin : g_lane
		ndd_div #(.DW(IW)) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.num    (sat_add(tab_ra_q[c], -$signed(tab_rb_q[c]))),
			.den    (node_gap),
			.done   (div_done[c]),
			.quot   (quot[c])
		);
		ndd_mul u_mul (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (mul_start),
			.a      (tab_ra_q[c]),
			.b      (prod_q),
			.done   (mul_done[c]),
			.prod   (term[c])
		);
	end

	ndd_mul u_prod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (prod_q),
		.b      (fac_ext),
		.done   (prod_done),
		.prod   (prod_next)
	);

	// Memory addressing by state
	always_comb begin
		pv_we       = 1'b0;
		pv_waddr    = idx_in;
		pv_wdata    = {value_w, value_z, value_y, value_x};
		pv_raddr    = pos_a;
		pos_we      = 1'b0;
		pos_waddr   = s_q;
		pos_wdata   = pos_a;
		pos_ra_addr = row_q[IW-1:0];
		pos_rb_addr = row_q[IW-1:0];
		slt_we      = 1'b0;
		slt_waddr   = idx_q;
		slt_wdata   = last;
		slt_raddr   = idx_in;
		tab_we      = 1'b0;
		tab_waddr   = {col_q[IW-1:0], row_q[IW-1:0]};
		tab_wdata   = '0;
		tab_ra_addr = {col_m1[IW-1:0], row_p1[IW-1:0]};
		tab_rb_addr = {col_m1[IW-1:0], row_q[IW-1:0]};
		div_start   = 1'b0;
		mul_start   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pv_we = in_xfer && (command == CMD_SET) && idx_ok;
			end
			ST_MV_SLOT: begin
				pos_ra_addr = last;
			end
			ST_MV_OTHER: begin
				slt_we    = 1'b1;
				slt_waddr = idx_q;
				slt_wdata = last;
				pos_we    = 1'b1;
				pos_waddr = s_q;
				pos_wdata = pos_a;
			end
			ST_MV_SWAP: begin
				slt_we    = 1'b1;
				slt_waddr = other_q;
				slt_wdata = s_q;
				pos_we    = 1'b1;
				pos_waddr = last;
				pos_wdata = idx_q;
			end
			ST_RB0_VAL: begin
				pv_raddr = pos_a;
			end
			ST_RB0_WR: begin
				tab_we    = 1'b1;
				tab_waddr = {IW'(0), row_q[IW-1:0]};
				for (int c = 0; c < 4; c++) begin
					tab_wdata[c] = {{8{pv_eff[c][31]}}, pv_eff[c], 24'd0};
				end
			end
			ST_RB_RD: begin
				pos_ra_addr = row_pc[IW-1:0];
				pos_rb_addr = row_q[IW-1:0];
			end
			ST_RB_DIV: begin
				div_start = 1'b1;
			end
			ST_RB_WR: begin
				tab_we = &div_done;
				for (int c = 0; c < 4; c++) begin
					tab_wdata[c] = quot[c];
				end
			end
			ST_EV_RD: begin
				tab_ra_addr = {i_q[IW-1:0], IW'(0)};
				pos_ra_addr = i_q[IW-1:0];
			end
			ST_EV_MUL: begin
				mul_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Memories: one write port, registered reads
	always_ff @(posedge clk) begin
		if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
		pv_rd_q   <= pv_mem[pv_raddr];
		pv_rvld_q <= pv_vld_q[pv_raddr];
	end

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
		pos_ra_q      <= pos_mem[pos_ra_addr];
		pos_rb_q      <= pos_mem[pos_rb_addr];
		pos_ra_vld_q  <= pos_vld_q[pos_ra_addr];
		pos_rb_vld_q  <= pos_vld_q[pos_rb_addr];
		pos_ra_addr_q <= pos_ra_addr;
		pos_rb_addr_q <= pos_rb_addr;
	end

	always_ff @(posedge clk) begin
		if (slt_we) slt_mem[slt_waddr] <= slt_wdata;
		slt_rd_q    <= slt_mem[slt_raddr];
		slt_rvld_q  <= slt_vld_q[slt_raddr];
		slt_raddr_q <= slt_raddr;
	end

	always_ff @(posedge clk) begin
		if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
		tab_ra_q <= tab_mem[tab_ra_addr];
		tab_rb_q <= tab_mem[tab_rb_addr];
	end

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			stale_q     <= '0;
			d_q         <= '0;
			row_q       <= '0;
			col_q       <= '0;
			i_q         <= '0;
			idx_q       <= '0;
			s_q         <= '0;
			other_q     <= '0;
			ts_q        <= '0;
			prod_q      <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
			pv_vld_q    <= '0;
			pos_vld_q   <= '0;
			slt_vld_q   <= '0;
			for (int c = 0; c < 4; c++) acc_q[c] <= '0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) out_valid_q <= 1'b0;
			if (pv_we)  pv_vld_q[pv_waddr]   <= 1'b1;
			if (pos_we) pos_vld_q[pos_waddr] <= 1'b1;
			if (slt_we) slt_vld_q[slt_waddr] <= 1'b1;

			// New count: identity order, drop points past the count, all stale
			if (cfg_wr && (cfg_n != cnt_q)) begin
				cnt_q     <= cfg_n;
				stale_q   <= '0;
				pos_vld_q <= '0;
				slt_vld_q <= '0;
				for (int p = 0; p < MAX_POINTS; p++) begin
					if (32'(p) >= 32'(cfg_n)) pv_vld_q[p] <= 1'b0;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						idx_q <= idx_in;
						if ((command == CMD_SET) && idx_ok) begin
							state_q <= ST_SET;
						end else if ((command == CMD_MOVE) && idx_ok) begin
							state_q <= ST_MV_SLOT;
						end else if (command == CMD_SAMPLE) begin
							ts_q    <= TSW'(t_sat) * TSW'(cnt_q - CW'(1));
							prod_q  <= PROD_ONE;
							i_q     <= '0;
							d_q     <= stale_q;
							row_q   <= stale_q;
							col_q   <= '0;
							stale_q <= CW'(MAX_POINTS);
							for (int c = 0; c < 4; c++) acc_q[c] <= '0;
							if (cnt_q == '0) begin
								state_q <= ST_OUT;
							end else if (stale_q < cnt_q) begin
								state_q <= ST_RB0_POS;
							end else begin
								state_q <= ST_EV_RD;
							end
						end
					end
				end
				ST_SET: begin
					if (CW'(slt_a) < stale_q) stale_q <= CW'(slt_a);
					state_q <= ST_IDLE;
				end
				ST_MV_SLOT: begin
					if (slt_a == last) begin
						state_q <= ST_IDLE;
					end else begin
						s_q <= slt_a;
						if (CW'(slt_a) < stale_q) stale_q <= CW'(slt_a);
						state_q <= ST_MV_OTHER;
					end
				end
				ST_MV_OTHER: begin
					other_q <= pos_a;
					state_q <= ST_MV_SWAP;
				end
				ST_MV_SWAP: begin
					state_q <= ST_IDLE;
				end
				// Column 0: slot value scaled to Q24.40
				ST_RB0_POS: begin
					state_q <= ST_RB0_VAL;
				end
				ST_RB0_VAL: begin
					state_q <= ST_RB0_WR;
				end
				ST_RB0_WR: begin
					if (row_p1 < cnt_q) begin
						row_q   <= row_p1;
						state_q <= ST_RB0_POS;
					end else if (cnt_q > CW'(1)) begin
						col_q   <= CW'(1);
						row_q   <= (d_q > CW'(1)) ? (d_q - CW'(1)) : '0;
						state_q <= ST_RB_RD;
					end else begin
						state_q <= ST_EV_RD;
					end
				end
				// Higher columns from the first stale row on
				ST_RB_RD: begin
					state_q <= ST_RB_DIV;
				end
				ST_RB_DIV: begin
					state_q <= ST_RB_WR;
				end
				ST_RB_WR: begin
					if (&div_done) begin
						if ((row_pc + CW'(1)) < cnt_q) begin
							row_q   <= row_p1;
							state_q <= ST_RB_RD;
						end else if ((col_q + CW'(1)) < cnt_q) begin
							col_q   <= col_q + CW'(1);
							row_q   <= (d_q > (col_q + CW'(1))) ? (d_q - col_q - CW'(1)) : '0;
							state_q <= ST_RB_RD;
						end else begin
							state_q <= ST_EV_RD;
						end
					end
				end
				// Newton form, one term per pass
				ST_EV_RD: begin
					state_q <= ST_EV_MUL;
				end
				ST_EV_MUL: begin
					state_q <= ST_EV_ACC;
				end
				ST_EV_ACC: begin
					if ((&mul_done) && prod_done) begin
						for (int c = 0; c < 4; c++) acc_q[c] <= sat_add(acc_q[c], term[c]);
						prod_q <= prod_next;
						if ((i_q + CW'(1)) == cnt_q) begin
							state_q <= ST_OUT;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= ST_EV_RD;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						for (int c = 0; c < 4; c++) res_q[c] <= to_q16(acc_q[c]);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result_x  = $signed(res_q[0]);
	assign result_y  = $signed(res_q[1]);
	assign result_z  = $signed(res_q[2]);
	assign result_w  = $signed(res_q[3]);

endmodule

FILE: tb/newton_divided_difference_interp_test.sv
// Self-checking bench: Newton interpolator commands against a cycle-free interpolation predictor.
`timescale 1ns / 1ps
module newton_divided_difference_interp_test;
	import ndd_pkg::*;

	localparam int NPTS = 16;
	localparam logic signed [63:0] QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] QMIN = -64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [1:0] CMD_RSVD = 2'd3;

	typedef struct {
		logic [1:0]         cmd;
		logic [3:0]         idx;
		logic signed [31:0] v [4];
		logic [16:0]        t;
	} req_t;

	typedef struct {
		logic signed [31:0] r [4];
	} sample_t;

	// directed row: request, optional typed-in result
	typedef struct {
		req_t    rq;
		bit      fixed;
		sample_t want;
	} drow_t;

	logic clk = 0, arst_n = 1;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PAW-1:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic [1:0] command = '0;
	logic [3:0] point_index = '0;
	logic signed [31:0] value_x = '0, value_y = '0, value_z = '0, value_w = '0;
	logic [16:0] sample_position = '0;
	logic out_valid, out_stall = 0;
	logic signed [31:0] result_x, result_y, result_z, result_w;

	newton_divided_difference_interp #(.MAX_POINTS(NPTS)) u_top (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#100ms;
		$display("simulation failed");
		$finish;
	end

	// predictor state
	logic signed [63:0] pt_val [NPTS][4];
	int slot_of [NPTS];
	int pt_at [NPTS];
	logic signed [63:0] ddt [NPTS][NPTS][4];
	int stale_from;
	int npts;

	sample_t samples_due [$];
	int errors = 0;
	int hold_cycles = 0;

	function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(QMAX)) return QMAX;
		if (s < 65'(QMIN)) return QMIN;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] mulq(logic signed [63:0] a, logic signed [63:0] b);
		logic [63:0] ma, mb, m;
		logic [127:0] p;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = (128'(ma) * 128'(mb)) >> 16;
		m = (p[127:64] != 0 || p[63:0] > 64'(QMAX)) ? 64'(QMAX) : p[63:0];
		return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] to_q16(logic signed [63:0] v);
		logic [63:0] m;
		m = (v < 0 ? -v : v) >> 24;
		if (v < 0) begin
			if (m > 64'h8000_0000) m = 64'h8000_0000;
			return 32'(-$signed(m));
		end
		if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
		return 32'(m);
	endfunction

	task automatic count_write_model(int n);
		if (n > NPTS) n = NPTS;
		if (n == npts) return;
		npts = n;
		for (int i = 0; i < NPTS; i++) begin
			slot_of[i] = i;
			pt_at[i] = i;
			if (i >= n) for (int c = 0; c < 4; c++) pt_val[i][c] = 0;
		end
		stale_from = 0;
	endtask

	task automatic refresh_table();
		int d, row;
		logic signed [63:0] gap;
		d = stale_from;
		if (d < npts) begin
			for (int s = d; s < npts; s++)
				for (int c = 0; c < 4; c++) ddt[0][s][c] = pt_val[pt_at[s]][c] <<< 24;
			for (int col = 1; col < npts; col++)
				for (row = (d > col ? d - col : 0); row < npts - col; row++) begin
					gap = pt_at[row + col] - pt_at[row];
					for (int c = 0; c < 4; c++)
						ddt[col][row][c] = add_sat(ddt[col-1][row+1][c], -ddt[col-1][row][c])
							/ gap;
				end
		end
		stale_from = NPTS;
	endtask

	// applies one accepted request; queues the expected sample if any
	task automatic interp_apply(req_t rq);
		logic signed [63:0] acc [4], prod, ts;
		int s, other;
		sample_t e;
		case (rq.cmd)
			CMD_SET: if (rq.idx < npts) begin
				for (int c = 0; c < 4; c++) pt_val[rq.idx][c] = rq.v[c];
				if (slot_of[rq.idx] < stale_from) stale_from = slot_of[rq.idx];
			end
			CMD_MOVE: if (rq.idx < npts && slot_of[rq.idx] != npts - 1) begin
				s = slot_of[rq.idx];
				other = pt_at[npts - 1];
				if (s < stale_from) stale_from = s;
				slot_of[rq.idx] = npts - 1;
				slot_of[other] = s;
				pt_at[s] = other;
				pt_at[npts - 1] = rq.idx;
			end
			CMD_SAMPLE: begin
				for (int c = 0; c < 4; c++) acc[c] = 0;
				refresh_table();
				if (npts > 0) begin
					ts = (rq.t > T_ONE ? 64'(T_ONE) : 64'(rq.t)) * (npts - 1);
					prod = PROD_ONE;
					for (int i = 0; i < npts; i++) begin
						for (int c = 0; c < 4; c++) acc[c] = add_sat(acc[c], mulq(ddt[i][0][c], prod));
						if (i == npts - 1) break;
						prod = mulq(prod, ts - 64'(pt_at[i]) * 65536);
					end
				end
				for (int c = 0; c < 4; c++) e.r[c] = to_q16(acc[c]);
				samples_due.insert(samples_due.size(), e);
			end
			default: ;
		endcase
	endtask

	task automatic apb_write(logic [31:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; paddr <= ADDR_POINT_COUNT; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		count_write_model(int'(val[4:0]));
	endtask

	// wait for all samples, then let the sequencer drain
	task automatic settle();
		while (samples_due.size() != 0) @(posedge clk);
		repeat (4000) @(posedge clk);
	endtask

	task automatic send(req_t rq);
		@(posedge clk);
		in_valid <= 1;
		command <= rq.cmd;
		point_index <= rq.idx;
		value_x <= rq.v[0]; value_y <= rq.v[1]; value_z <= rq.v[2]; value_w <= rq.v[3];
		sample_position <= rq.t;
		do @(posedge clk); while (in_stall);
		interp_apply(rq);
		in_valid <= 0;
	endtask

	function automatic req_t rnd_req(bit sane);
		req_t rq;
		int k;
		k = $urandom_range(0, 99);
		rq.cmd = k < 45 ? CMD_SET : k < 70 ? CMD_MOVE : k < 97 ? CMD_SAMPLE : CMD_RSVD;
		rq.idx = sane && npts > 0 ? 4'($urandom_range(0, npts - 1)) : 4'($urandom);
		for (int c = 0; c < 4; c++)
			case ($urandom_range(0, 3))
				0: rq.v[c] = $urandom;
				1: rq.v[c] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
				2: rq.v[c] = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
				default: rq.v[c] = $signed($urandom_range(0, 1 << 12)) <<< 16;
			endcase
		rq.t = $urandom_range(0, 9) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
		return rq;
	endfunction

	// output checker
	always @(posedge clk) begin
		sample_t e, got;
		if (out_valid && !out_stall) begin
			got.r[0] = result_x; got.r[1] = result_y; got.r[2] = result_z; got.r[3] = result_w;
			if (samples_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h %h %h %h",
					result_x, result_y, result_z, result_w);
			end else begin
				e = samples_due.pop_front();
				for (int c = 0; c < 4; c++)
					if (e.r[c] !== got.r[c]) begin
						errors++;
						if (errors <= 10)
							$display("component %0d: expected %h got %h", c, e.r[c], got.r[c]);
					end
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1;
		end else
			out_stall <= $urandom_range(0, 3) == 0 && $urandom_range(0, 1);
	end

	// directed table
	drow_t dtab [$];

	task automatic add_row(logic [1:0] cmd, int idx, logic signed [31:0] v, logic [16:0] t,
			bit fixed, logic signed [31:0] want);
		drow_t r;
		r.rq.cmd = cmd;
		r.rq.idx = 4'(idx);
		for (int c = 0; c < 4; c++) r.rq.v[c] = c[0] ? ~v : v;
		r.rq.t = t;
		r.fixed = fixed;
		for (int c = 0; c < 4; c++) r.want.r[c] = want;
		dtab.insert(dtab.size(), r);
	endtask

	initial begin
		int burst;
		req_t rq;
		sample_t chk;
		arst_n <= 0;
		for (int i = 0; i < NPTS; i++) begin
			slot_of[i] = i; pt_at[i] = i;
			for (int c = 0; c < 4; c++) pt_val[i][c] = 0;
		end
		stale_from = 0;
		npts = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// no points: sample gives zero
		add_row(CMD_SAMPLE, 0, 0, 17'd1000, 1, 0);
		add_row(CMD_SET, 3, 32'sh1234, 0, 0, 0);
		for (int p = 0; p < NPTS; p++)
			add_row(CMD_SET, p, p[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000 + p, 0, 0, 0);
		add_row(CMD_SAMPLE, 0, 0, 17'd0, 0, 0);
		add_row(CMD_MOVE, 2, 0, 0, 0, 0);
		add_row(CMD_MOVE, 2, 0, 0, 0, 0);       // already last
		add_row(CMD_RSVD, 0, 0, 0, 0, 0);
		add_row(CMD_SAMPLE, 0, 0, 17'd65536, 0, 0);
		add_row(CMD_SAMPLE, 0, 0, 17'h1FFFF, 0, 0);   // position too large
		add_row(CMD_SAMPLE, 0, 0, 17'd32768, 0, 0);

		for (int i = 0; i < dtab.size(); i++) begin
			if (i == 1) begin
				settle();
				apb_write(32'd31);   // count too large
			end
			send(dtab[i].rq);
			if (dtab[i].fixed) begin
				chk = samples_due[$];
				for (int c = 0; c < 4; c++)
					if (chk.r[c] !== dtab[i].want.r[c]) begin
						errors++;
						if (errors <= 10)
							$display("fixed row %0d component %0d: expected %h got %h",
								i, c, dtab[i].want.r[c], chk.r[c]);
					end
			end
		end

		// random phases over several counts
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph)
				0: apb_write(32'd2);
				1: apb_write(32'd1);
				2: apb_write(32'd16);
				3: apb_write(32'd0);
				default: apb_write(32'($urandom_range(2, 8)));
			endcase
			for (int k = 0; k < 140; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && k < 140; b++, k++) begin
					rq = rnd_req($urandom_range(0, 9) != 0);
					if (ph == 2 && k == 40) hold_cycles = 3000;
					send(rq);
				end
				if (ph == 3 && k > 70 && k < 80)
					while (samples_due.size() != 0) @(posedge clk);
				repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 20)) @(posedge clk);
			end
		end

		settle();
		if (errors == 0 && samples_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
